// ===== src/udfeb_pkg.sv =====
package udfeb_pkg;

  localparam int RX_DEPTH_DEF = 1024;
  localparam int TX_DEPTH_DEF = 1024;

  localparam logic [1:0] REQ_RX_BYTE = 2'd0;
  localparam logic [1:0] REQ_TX_DONE = 2'd1;
  localparam logic [1:0] REQ_HOST_RD = 2'd2;
  localparam logic [1:0] REQ_HOST_WR = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } udfeb_cmd_t;

  typedef struct packed {
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       tx_busy;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       rx_dropped;
    logic       write_accepted;
  } udfeb_res_t;

endpackage

// ===== src/udfeb_if.sv =====
interface udfeb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface udfeb_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_start;
  logic [7:0] tx_byte;
  logic       tx_busy;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       rx_dropped;
  logic       write_accepted;

  modport source (output valid, output tx_start, output tx_byte, output tx_busy,
                  output read_valid, output read_byte, output rx_dropped,
                  output write_accepted, input ready);
  modport sink (input valid, input tx_start, input tx_byte, input tx_busy,
                input read_valid, input read_byte, input rx_dropped,
                input write_accepted, output ready);
endinterface

// ===== src/udfeb_ctrl.sv =====
module udfeb_ctrl
  import udfeb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output udfeb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == S_IDLE) || ((state == S_RESP) && out_ready);
  assign out_valid   = (state == S_RESP);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== src/udfeb_dp.sv =====
module udfeb_dp
  import udfeb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  udfeb_cmd_t cmd,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [1:0] in_type,
  input  logic [7:0] in_data,
  output udfeb_res_t res
);

  localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_PW-1:0] rx_wp, rx_rp, rx_wp_inc, rx_rp_inc;
  logic [TX_PW-1:0] tx_wp, tx_rp, tx_wp_inc, tx_rp_inc;
  logic [7:0]       rx_rd_q, tx_rd_q;
  logic             busy, busy_next, loopback;
  logic [1:0]       req_q;
  logic [7:0]       data_q;

  logic rx_empty, rx_full, tx_empty, tx_full;
  logic rx_push, rx_pop, tx_push, tx_pop;
  udfeb_res_t res_next;

  assign rx_wp_inc = (rx_wp == RX_LAST) ? '0 : rx_wp + RX_PW'(1);
  assign rx_rp_inc = (rx_rp == RX_LAST) ? '0 : rx_rp + RX_PW'(1);
  assign tx_wp_inc = (tx_wp == TX_LAST) ? '0 : tx_wp + TX_PW'(1);
  assign tx_rp_inc = (tx_rp == TX_LAST) ? '0 : tx_rp + TX_PW'(1);

  assign rx_empty = (rx_wp == rx_rp);
  assign rx_full  = (rx_wp_inc == rx_rp);
  assign tx_empty = (tx_wp == tx_rp);
  assign tx_full  = (tx_wp_inc == tx_rp);

  always_comb begin
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    busy_next = busy;
    res_next  = '0;
    unique case (req_q)
      REQ_RX_BYTE, REQ_HOST_WR: begin
        if (req_q == REQ_HOST_WR || loopback) begin
          tx_push                 = !tx_full;
          res_next.write_accepted = !tx_full;
          // idle start: oldest queued byte, or the one just pushed
          if (!busy && (!tx_empty || !tx_full)) begin
            tx_pop           = 1'b1;
            busy_next        = 1'b1;
            res_next.tx_start = 1'b1;
            res_next.tx_byte  = tx_empty ? data_q : tx_rd_q;
          end
        end
        if (req_q == REQ_RX_BYTE) begin
          rx_push             = !rx_full;
          res_next.rx_dropped = rx_full;
        end
      end
      REQ_TX_DONE: begin
        if (busy) begin
          if (!tx_empty) begin
            tx_pop            = 1'b1;
            res_next.tx_start = 1'b1;
            res_next.tx_byte  = tx_rd_q;
          end else begin
            busy_next = 1'b0;
          end
        end
      end
      REQ_HOST_RD: begin
        if (!rx_empty) begin
          rx_pop              = 1'b1;
          res_next.read_valid = 1'b1;
          res_next.read_byte  = rx_rd_q;
        end
      end
      default: begin
        busy_next = busy;
      end
    endcase
    res_next.tx_busy = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp    <= '0;
      rx_rp    <= '0;
      tx_wp    <= '0;
      tx_rp    <= '0;
      busy     <= 1'b0;
      loopback <= 1'b1;
    end else begin
      if (cfg_we) loopback <= cfg_wdata;
      if (cmd.exec) begin
        if (rx_push) rx_wp <= rx_wp_inc;
        if (rx_pop)  rx_rp <= rx_rp_inc;
        if (tx_push) tx_wp <= tx_wp_inc;
        if (tx_pop)  tx_rp <= tx_rp_inc;
        busy <= busy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= in_type;
      data_q <= in_data;
    end
    if (cmd.exec) res <= res_next;
  end

  // storage: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.exec && rx_push) rx_mem[rx_wp] <= data_q;
    rx_rd_q <= rx_mem[rx_rp];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && tx_push) tx_mem[tx_wp] <= data_q;
    tx_rd_q <= tx_mem[tx_rp];
  end

  // an idle transmitter never leaves bytes queued
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> tx_empty)
    else $error("transmitter idle with bytes queued");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (!res.tx_start || res.tx_busy))
    else $error("start reported with transmitter idle");

  a_drop_rx_only: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (req_q != REQ_RX_BYTE) |=> !res.rx_dropped)
    else $error("drop flagged for a non-receive transaction");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(rx_wp) && $stable(rx_rp) && $stable(tx_wp) && $stable(tx_rp))
    else $error("pointer moved outside execute");

endmodule

// ===== src/uart_dual_fifo_echo_buffer.sv =====
// channel  dir  handshake    payload
// cfg      in   cfg_we       cfg_wdata (loopback_enable)
// req      in   valid/ready  req_type, data_byte
// rsp      out  valid/ready  tx_start, tx_byte, tx_busy, read_valid,
//                            read_byte, rx_dropped, write_accepted
//
// Each transaction is captured, then run in the execute state against the
// FIFO pointers and the registered read port of each ring store.
// A new request is taken in the cycle the response is taken.
// rst is synchronous: pointers cleared, transmitter idle, loopback on.
// A stalled response holds; no request is taken until it leaves.
module uart_dual_fifo_echo_buffer
  import udfeb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  udfeb_req_if.sink   req,
  udfeb_rsp_if.source rsp
);

  udfeb_cmd_t cmd;
  udfeb_res_t res;

  udfeb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  udfeb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_type   (req.req_type),
    .in_data   (req.data_byte),
    .res       (res)
  );

  assign rsp.tx_start       = res.tx_start;
  assign rsp.tx_byte        = res.tx_byte;
  assign rsp.tx_busy        = res.tx_busy;
  assign rsp.read_valid     = res.read_valid;
  assign rsp.read_byte      = res.read_byte;
  assign rsp.rx_dropped     = res.rx_dropped;
  assign rsp.write_accepted = res.write_accepted;

endmodule
